FILE: design/oaids_pkg.sv
package oaids_pkg;

   localparam int DEPTH   = 128;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam int OP_W    = 3;
   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int FOUND_W = 7;

   localparam int REQ_DATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_BITS   = FOUND_W + VALUE_W + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                      en;
      logic [ADDR_W-1:0]         addr;
      logic signed [VALUE_W-1:0] data;
   } ram_wr_type;

endpackage

FILE: design/oaids_ram.sv
module oaids_ram
   import oaids_pkg::*;
(
   input  logic                      clock,
   input  ram_wr_type                wr,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic signed [VALUE_W-1:0] rd_data
);

   logic signed [VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/ordered_array_insert_delete_search.sv
// one item at a time; req_tready is high only while no command is in progress
// insert at p below count c shifts entries p..c-1 up by one, then writes; append writes at c
// delete at p shifts entries p+1..c-1 down; search scans from index 0 to the first hit
// clear, empty search and rejected commands go straight to the result; a stalled result holds
// its item until taken; synchronous reset empties the array (count 0) and drops any pending result;
// array contents are not cleared
module ordered_array_insert_delete_search
   import oaids_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position, value
   input  logic [OP_W-1:0]       req_tuser,  // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_index, read_value, count, zero pad
   output logic [STAT_W-1:0]     rsp_tuser   // status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_SEARCH,
      S_READ,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]         ptr_ff, ptr_in;
   logic [ADDR_W-1:0]         pa_ff, pa_in;
   logic                      run_ff, run_in;
   logic                      pend_ff, pend_in;
   status_type                res_status_ff, res_status_in;
   logic [FOUND_W-1:0]        res_found_ff, res_found_in;
   logic signed [VALUE_W-1:0] res_read_ff, res_read_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]        rsp_found_ff, rsp_found_in;
   logic signed [VALUE_W-1:0] rsp_read_ff, rsp_read_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;

   op_type                    req_op;
   logic [POS_W-1:0]          req_pos;
   logic signed [VALUE_W-1:0] req_val;
   ram_wr_type                wr;
   logic [ADDR_W-1:0]         rd_addr;
   logic signed [VALUE_W-1:0] rd_data;

   assign req_op  = op_type'(req_tuser);
   assign req_pos = req_tdata[POS_W-1:0];
   assign req_val = req_tdata[POS_W +: VALUE_W];

   oaids_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      pa_in         = pa_ff;
      run_in        = run_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_read_in   = res_read_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      wr            = '{en: 1'b0, addr: '0, data: '0};
      rd_addr       = ptr_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = req_pos[ADDR_W-1:0];
            if (req_tvalid) begin
               pos_in        = req_pos;
               val_in        = req_val;
               res_status_in = ST_OK;
               res_found_in  = '0;
               res_read_in   = '0;
               run_in        = 1'b1;
               pend_in       = 1'b0;
               state_in      = S_DONE;
               case (req_op)
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  OP_INSERT: begin
                     if (CNT_W'(req_pos) > cnt_ff) begin
                        res_status_in = ST_INVALID;
                     end else if (cnt_ff == CNT_W'(DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else if (CNT_W'(req_pos) == cnt_ff) begin
                        wr     = '{en: 1'b1, addr: req_pos[ADDR_W-1:0], data: req_val};
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        ptr_in   = ADDR_W'(cnt_ff - 1'b1);
                        state_in = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     if (CNT_W'(req_pos) >= cnt_ff) begin
                        res_status_in = ST_INVALID;
                     end else if (CNT_W'(req_pos) + 1'b1 == cnt_ff) begin
                        cnt_in = cnt_ff - 1'b1;
                     end else begin
                        ptr_in   = ADDR_W'(req_pos + 1'b1);
                        state_in = S_SHIFT_DN;
                     end
                  end
                  OP_SEARCH: begin
                     if (cnt_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  OP_READ: begin
                     if (CNT_W'(req_pos) >= cnt_ff) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     res_status_in = ST_INVALID;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            if (pend_ff) begin
               wr = '{en: 1'b1, addr: ADDR_W'(pa_ff + 1'b1), data: rd_data};
            end else if (!run_ff) begin
               wr       = '{en: 1'b1, addr: pos_ff[ADDR_W-1:0], data: val_ff};
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_DONE;
            end
            if (run_ff) begin
               pa_in   = ptr_ff;
               pend_in = 1'b1;
               if (CNT_W'(ptr_ff) == CNT_W'(pos_ff)) begin
                  run_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
         end
         S_SHIFT_DN: begin
            if (pend_ff) begin
               wr = '{en: 1'b1, addr: ADDR_W'(pa_ff - 1'b1), data: rd_data};
            end else if (!run_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_DONE;
            end
            if (run_ff) begin
               pa_in   = ptr_ff;
               pend_in = 1'b1;
               if (CNT_W'(ptr_ff) == cnt_ff - 1'b1) begin
                  run_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
         end
         S_SEARCH: begin
            if (run_ff) begin
               pa_in   = ptr_ff;
               pend_in = 1'b1;
               if (CNT_W'(ptr_ff) == cnt_ff - 1'b1) begin
                  run_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && rd_data == val_ff) begin
               res_status_in = ST_OK;
               res_found_in  = FOUND_W'(pa_ff);
               state_in      = S_DONE;
            end else if (!pend_ff && !run_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end
         S_READ: begin
            res_read_in = rd_data;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_read_in   = res_read_ff;
               rsp_count_in  = cnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         run_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      pa_ff         <= pa_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_read_ff   <= res_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, rsp_count_ff, rsp_read_ff,
                        rsp_found_ff};

endmodule

FILE: design/oaids_checker.sv
module oaids_checker
   import oaids_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STAT_W-1:0]     rsp_tuser
);

   logic [FOUND_W-1:0]        found;
   logic signed [VALUE_W-1:0] rd_val;
   logic [CNT_W-1:0]          count;

   assign found  = rsp_tdata[FOUND_W-1:0];
   assign rd_val = rsp_tdata[FOUND_W +: VALUE_W];
   assign count  = rsp_tdata[FOUND_W + VALUE_W +: CNT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= CNT_W'(DEPTH))
      else $error("count above depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> count == CNT_W'(DEPTH))
      else $error("full status with room left");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> found == '0 && rd_val == '0)
      else $error("failed command returned data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind ordered_array_insert_delete_search oaids_checker u_oaids_checker (.*);

FILE: test/ordered_array_insert_delete_search_test.sv
module ordered_array_insert_delete_search_test;
   import oaids_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 160;
   localparam int PRESSURE_CYCLES = 300;

   localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      status_type                status;
      logic [FOUND_W-1:0]        found_index;
      logic signed [VALUE_W-1:0] read_value;
      logic [CNT_W-1:0]          count;
   } array_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // position, value
   logic [OP_W-1:0]       req_tuser = '0;  // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // found_index, read_value, count, zero pad
   logic [STAT_W-1:0]     rsp_tuser;       // status

   logic signed [VALUE_W-1:0] shadow_array [DEPTH];
   int                        shadow_count = 0;
   array_outcome_type         array_outcomes_due [$];
   array_outcome_type         outcome_head;

   int error_count = 0;
   int cycle_count = 0;
   int rsp_pressure_hold = 0;
   bit steady = 1'b0;

   ordered_array_insert_delete_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ordered_array_insert_delete_search] ERROR");
         $finish;
      end
   end

   function automatic array_outcome_type predict_array_op(input logic [OP_W-1:0] op,
                                                          input logic [POS_W-1:0] pos,
                                                          input logic signed [VALUE_W-1:0] value);
      array_outcome_type r;
      r.status = ST_OK;
      r.found_index = '0;
      r.read_value = '0;
      case (op)
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_INSERT: begin
            if (pos > shadow_count) begin
               r.status = ST_INVALID;
            end else if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > pos; i--)
                  shadow_array[ADDR_W'(i)] = shadow_array[ADDR_W'(i - 1)];
               shadow_array[pos[ADDR_W-1:0]] = value;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (pos >= shadow_count) begin
               r.status = ST_INVALID;
            end else begin
               for (int i = pos; i + 1 < shadow_count; i++)
                  shadow_array[ADDR_W'(i)] = shadow_array[ADDR_W'(i + 1)];
               shadow_count--;
            end
         end
         OP_SEARCH: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_array[ADDR_W'(i)] == value) begin
                  r.status = ST_OK;
                  r.found_index = FOUND_W'(i);
                  break;
               end
            end
         end
         OP_READ: begin
            if (pos >= shadow_count) r.status = ST_INVALID;
            else r.read_value = shadow_array[pos[ADDR_W-1:0]];
         end
         default: begin
            r.status = ST_INVALID;
         end
      endcase
      r.count = CNT_W'(shadow_count);
      return r;
   endfunction

   task automatic issue_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_W'({value, pos});
      do @(posedge clock); while (!req_tready);
      array_outcomes_due.push_back(predict_array_op(op, pos, value));
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return $urandom_range(0, 15);
      if (roll < 40) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // result side: per-item stall, plus one long hold-off on request
   initial begin
      int hold;
      wait (!reset);
      forever begin
         @(negedge clock);
         hold = steady ? 0 : $urandom_range(0, 7);
         if (rsp_pressure_hold > 0) begin
            hold = rsp_pressure_hold;
            rsp_pressure_hold = 0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (array_outcomes_due.size() == 0) begin
            $error("result item with no command pending");
            error_count++;
         end else begin
            outcome_head = array_outcomes_due.pop_front();
            if (rsp_tuser !== outcome_head.status) begin
               $error("status: expected %0d, actual %0d", outcome_head.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[FOUND_W-1:0] !== outcome_head.found_index) begin
               $error("found_index: expected %0d, actual %0d", outcome_head.found_index,
                      rsp_tdata[FOUND_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[FOUND_W +: VALUE_W] !== outcome_head.read_value) begin
               $error("read_value: expected %0d, actual %0d", outcome_head.read_value,
                      $signed(rsp_tdata[FOUND_W +: VALUE_W]));
               error_count++;
            end
            if (rsp_tdata[FOUND_W + VALUE_W +: CNT_W] !== outcome_head.count) begin
               $error("count: expected %0d, actual %0d", outcome_head.count,
                      rsp_tdata[FOUND_W + VALUE_W +: CNT_W]);
               error_count++;
            end
         end
      end
   end

   task automatic test_edge_cases();
      issue_command(OP_CLEAR, 8'hff, -1);
      issue_command(OP_READ, 0, 0);
      issue_command(OP_DELETE, 0, 0);
      issue_command(OP_SEARCH, 0, 0);
      issue_command(OP_INSERT, 1, 7);            // beyond end on empty array
      issue_command(OP_INSERT, 0, VALUE_MIN);
      issue_command(OP_INSERT, 1, VALUE_MAX);
      issue_command(OP_INSERT, 0, 0);            // shifts both up
      issue_command(OP_INSERT, 3, -1);
      issue_command(OP_INSERT, 2, VALUE_MAX);    // duplicate key
      issue_command(OP_SEARCH, 8'hff, VALUE_MAX);
      issue_command(OP_SEARCH, 0, VALUE_MIN);
      issue_command(OP_SEARCH, 0, 32'sh1234_5678);
      issue_command(OP_READ, 4, 0);
      issue_command(OP_READ, 5, 0);
      issue_command(OP_READ, 128, 0);
      issue_command(OP_READ, 8'hff, 0);
      issue_command(OP_DELETE, 200, 0);
      issue_command(OP_DELETE, 1, 0);
      issue_command(OP_DELETE, 3, 0);
      issue_command(OP_RSVD_5, 0, 0);
      issue_command(OP_RSVD_6, 1, -1);
      issue_command(OP_RSVD_7, 8'hff, VALUE_MAX);
      issue_command(OP_READ, 1, 0);
      issue_command(OP_INSERT, 6, 3);
   endtask

   task automatic test_full_array();
      issue_command(OP_CLEAR, 0, 0);
      while (shadow_count < DEPTH)
         issue_command(OP_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_value());
      issue_command(OP_INSERT, POS_W'(DEPTH), 1);
      issue_command(OP_INSERT, 0, 1);
      issue_command(OP_INSERT, POS_W'(DEPTH + 1), 1);    // invalid wins over full
      issue_command(OP_INSERT, 8'hff, 1);
      issue_command(OP_READ, POS_W'(DEPTH - 1), 0);
      issue_command(OP_READ, POS_W'(DEPTH), 0);
      issue_command(OP_SEARCH, 0, shadow_array[ADDR_W'(DEPTH - 1)]);
      issue_command(OP_DELETE, POS_W'(DEPTH - 1), 0);
      issue_command(OP_DELETE, 0, 0);
      issue_command(OP_INSERT, 0, VALUE_MIN);
      issue_command(OP_INSERT, POS_W'(shadow_count), VALUE_MAX);
      issue_command(OP_SEARCH, 0, VALUE_MAX);
   endtask

   task automatic test_random_mix(input int n);
      int unsigned roll;
      logic [OP_W-1:0] op;
      logic [POS_W-1:0] pos;
      logic signed [VALUE_W-1:0] value;
      for (int k = 0; k < n; k++) begin
         if (k % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 2) op = OP_CLEAR;
         else if (roll < 46) op = OP_INSERT;
         else if (roll < 64) op = OP_DELETE;
         else if (roll < 82) op = OP_SEARCH;
         else if (roll < 97) op = OP_READ;
         else begin
            case ($urandom_range(0, 2))
               0: op = OP_RSVD_5;
               1: op = OP_RSVD_6;
               default: op = OP_RSVD_7;
            endcase
         end
         value = pick_value();
         if (op == OP_SEARCH && shadow_count > 0 && $urandom_range(0, 1))
            value = shadow_array[ADDR_W'($urandom_range(0, shadow_count - 1))];
         pos = POS_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 85) begin
            if (op == OP_INSERT) pos = POS_W'($urandom_range(0, shadow_count));
            else if (shadow_count > 0) pos = POS_W'($urandom_range(0, shadow_count - 1));
         end
         issue_command(op, pos, value);
      end
      steady = 1'b0;
   endtask

   task automatic test_result_backpressure();
      rsp_pressure_hold = PRESSURE_CYCLES;
      for (int k = 0; k < 12; k++) begin
         if (k % 2 == 0)
            issue_command(OP_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_value());
         else issue_command(OP_READ, POS_W'($urandom_range(0, shadow_count)), 0);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_full_array();
      test_random_mix(870);
      test_result_backpressure();
      test_random_mix(15);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (array_outcomes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ordered_array_insert_delete_search] OK");
      end else begin
         $display("[ordered_array_insert_delete_search] ERROR");
      end
      $finish;
   end

endmodule
